FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// expr must hold at every clock edge outside reset
`define ASSERT_HOLDS(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed");
// cons must hold in the cycle after ante
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define ASSERT_HOLDS(lbl, clk, rst, expr)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

FILE: rtl/core/tkdd_pkg.sv
// Constants and codes of the keyed descrambler.
package tkdd_pkg;

   localparam int KEY_TABLE_DEPTH = 256;
   localparam int KEY_BANK_DEPTH  = KEY_TABLE_DEPTH / 2;
   localparam int KEY_BANK_AW     = $clog2(KEY_BANK_DEPTH);
   localparam int KEY_BYTE_W      = 8;
   localparam int WORD_W          = 16;
   localparam int MODE_W          = 4;
   localparam int CSR_INDEX_W     = 2;
   localparam int CSR_DATA_W      = 16;
   localparam int REQ_DATA_W      = 48;
   localparam int RSP_DATA_W      = 32;

   localparam logic OP_TABLE_WRITE = 1'b0;
   localparam logic OP_TRANSFER    = 1'b1;

   localparam logic [MODE_W-1:0] MODE_PLAIN = 4'd0;
   localparam logic [MODE_W-1:0] MODE_SUB   = 4'd1;
   localparam logic [MODE_W-1:0] MODE_ADD   = 4'd2;
   localparam logic [MODE_W-1:0] MODE_XOR   = 4'd3;
   localparam logic [MODE_W-1:0] MODE_COPY  = 4'd5;
   localparam logic [MODE_W-1:0] MODE_NREV  = 4'd6;

   localparam logic [CSR_INDEX_W-1:0] CSR_TRANSFER_MODE   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_OFFSET      = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_DEST_BASE       = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_TRANSFER_LENGTH = 2'd3;

endpackage

FILE: rtl/core/tkdd_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tkdd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/core/table_keyed_dma_descrambler_unit.sv
// Keyed DMA descrambler top level: key table banks, transform stage, output register.
// Each transfer word is registered in the transform stage, then in the output register.
// Throughput: one word per cycle unless rsp_tready stalls; one read port per key bank.
// Reset clears the control registers and pipeline valids; the key table is not cleared.
// A table write produces no result.
`include "assert_macros.svh"

module table_keyed_dma_descrambler_unit (
   input  logic                                  clock,
   input  logic                                  reset,
   // req_tdata: table_index[7:0], table_byte[15:8], source_word[31:16],
   //            word_position[47:32]
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [tkdd_pkg::REQ_DATA_W-1:0]       req_tdata,
   // req_tuser: opcode[0]
   input  logic                                  req_tuser,
   // rsp_tdata: dest_address[15:0], out_word[31:16]
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [tkdd_pkg::RSP_DATA_W-1:0]       rsp_tdata,
   output logic                                  rsp_tlast,
   input  logic                                  csr_we,
   input  logic [tkdd_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [tkdd_pkg::CSR_DATA_W-1:0]       csr_wdata
);
   import tkdd_pkg::*;

   // configuration
   logic [MODE_W-1:0]     mode_ff;
   logic [KEY_BYTE_W-1:0] key_offset_ff;
   logic [WORD_W-1:0]     dest_base_ff;
   logic [WORD_W-1:0]     length_ff;

   // input fields
   logic [KEY_BYTE_W-1:0] in_index;
   logic [KEY_BYTE_W-1:0] in_byte;
   logic [WORD_W-1:0]     in_src;
   logic [WORD_W-1:0]     in_pos;
   logic                  req_accept;
   logic                  is_write;
   logic                  is_transfer;
   logic                  mode_emits;

   // key banks: even bytes form the key high byte, odd bytes the low byte
   logic                   even_we;
   logic                   odd_we;
   logic                   key_rd_en;
   logic [KEY_BANK_AW-1:0] key_rd_addr;
   logic [KEY_BYTE_W-1:0]  even_rd;
   logic [KEY_BYTE_W-1:0]  odd_rd;

   // transform stage
   logic              s1_valid_ff, s1_valid_in;
   logic [WORD_W-1:0] s1_src_ff;
   logic [WORD_W-1:0] s1_pos_ff;
   logic              s1_ready;

   // output register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [WORD_W-1:0] rsp_addr_ff, rsp_addr_in;
   logic [WORD_W-1:0] rsp_word_ff, rsp_word_in;
   logic              rsp_last_ff, rsp_last_in;
   logic              advance;

   logic [WORD_W-1:0] key;
   logic [WORD_W-1:0] swapped;

   assign in_index = req_tdata[7:0];
   assign in_byte  = req_tdata[15:8];
   assign in_src   = req_tdata[31:16];
   assign in_pos   = req_tdata[47:32];

   assign req_accept  = req_tvalid && req_tready;
   assign is_write    = (req_tuser == OP_TABLE_WRITE);
   assign is_transfer = (req_tuser == OP_TRANSFER);
   assign mode_emits  = mode_ff inside {MODE_PLAIN, MODE_SUB, MODE_ADD, MODE_XOR,
                                        MODE_COPY, MODE_NREV};

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= '0;
         key_offset_ff <= '0;
         dest_base_ff  <= '0;
         length_ff     <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_TRANSFER_MODE:   mode_ff       <= csr_wdata[MODE_W-1:0];
            CSR_KEY_OFFSET:      key_offset_ff <= csr_wdata[KEY_BYTE_W-1:0];
            CSR_DEST_BASE:       dest_base_ff  <= csr_wdata;
            CSR_TRANSFER_LENGTH: length_ff     <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign even_we     = req_accept && is_write && !in_index[0];
   assign odd_we      = req_accept && is_write && in_index[0];
   assign key_rd_en   = req_accept && is_transfer;
   // byte address 2*pos + even offset, halved to a bank row
   assign key_rd_addr = in_pos[KEY_BANK_AW-1:0] + key_offset_ff[KEY_BYTE_W-1:1];

   tkdd_ram #(
      .WIDTH (KEY_BYTE_W),
      .DEPTH (KEY_BANK_DEPTH)
   ) u_even_bank (
      .clock   (clock),
      .wr_en   (even_we),
      .wr_addr (in_index[KEY_BYTE_W-1:1]),
      .wr_data (in_byte),
      .rd_en   (key_rd_en),
      .rd_addr (key_rd_addr),
      .rd_data (even_rd)
   );

   tkdd_ram #(
      .WIDTH (KEY_BYTE_W),
      .DEPTH (KEY_BANK_DEPTH)
   ) u_odd_bank (
      .clock   (clock),
      .wr_en   (odd_we),
      .wr_addr (in_index[KEY_BYTE_W-1:1]),
      .wr_data (in_byte),
      .rd_en   (key_rd_en),
      .rd_addr (key_rd_addr),
      .rd_data (odd_rd)
   );

   assign advance    = !rsp_valid_ff || rsp_tready;
   assign s1_ready   = !s1_valid_ff || advance;
   assign req_tready = s1_ready;

   always_comb begin
      if (s1_ready) begin
         s1_valid_in = req_accept && is_transfer && mode_emits;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   // bank read data holds while the stage stalls since reads follow accepts only
   always_ff @(posedge clock) begin
      if (key_rd_en) begin
         s1_src_ff <= in_src;
         s1_pos_ff <= in_pos;
      end
   end

   assign key     = {even_rd, odd_rd};
   assign swapped = {s1_src_ff[7:0], s1_src_ff[15:8]};

   always_comb begin
      case (mode_ff)
         MODE_PLAIN: rsp_word_in = swapped;
         MODE_SUB:   rsp_word_in = swapped - key;
         MODE_ADD:   rsp_word_in = swapped + key;
         MODE_XOR:   rsp_word_in = swapped ^ key;
         MODE_COPY:  rsp_word_in = s1_src_ff;
         MODE_NREV:  rsp_word_in = {s1_src_ff[3:0], s1_src_ff[7:4],
                                    s1_src_ff[11:8], s1_src_ff[15:12]};
         default:    rsp_word_in = s1_src_ff;
      endcase
   end

   assign rsp_addr_in  = dest_base_ff + s1_pos_ff;
   assign rsp_last_in  = (length_ff != '0) && (s1_pos_ff == length_ff - WORD_W'(1));
   assign rsp_valid_in = advance ? s1_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && s1_valid_ff) begin
         rsp_addr_ff <= rsp_addr_in;
         rsp_word_ff <= rsp_word_in;
         rsp_last_ff <= rsp_last_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_word_ff, rsp_addr_ff};
   assign rsp_tlast  = rsp_last_ff;

   `ASSERT_HOLDS(a_ready_when_empty, clock, reset, !s1_valid_ff -> req_tready)
   `ASSERT_NEXT(a_emit_enters_stage, clock, reset,
      req_accept && is_transfer && mode_emits, s1_valid_ff)
   `ASSERT_NEXT(a_write_no_stage, clock, reset, req_accept && is_write, !s1_valid_ff)
   `ASSERT_NEXT(a_stage_to_output, clock, reset, s1_valid_ff && advance, rsp_tvalid)

endmodule
